@@ sv/rqps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and compare functions of the ready queue selector.
// Used by rqps_engine and the top level; depends on nothing.
package rqps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int QCNT_W      = 5;

    typedef enum logic { OP_INSERT = 1'b0, OP_SELECT = 1'b1 } op_t;

    typedef enum logic [1:0]
    {
        POL_FCFS = 2'd0,
        POL_SJF  = 2'd1,
        POL_SRTF = 2'd2,
        POL_PRIO = 2'd3
    } policy_t;

    typedef enum logic [1:0]
    {
        STS_DONE  = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2,
        STS_KEPT  = 2'd3
    } status_t;

    // One queue record, packed as priority[63:56] .. id[7:0]
    typedef struct packed
    {
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [7:0]  id;
    } task_rec_t;

    localparam int REC_W = $bits(task_rec_t);

    // Command beat captured at accept
    typedef struct packed
    {
        op_t         op;
        task_rec_t   rec;
        logic        cur_valid;
        logic [15:0] cur_rem;
    } cmd_t;

    // Result beat
    typedef struct packed
    {
        status_t           status;
        task_rec_t         rec;
        logic [QCNT_W-1:0] qcount;
    } result_t;

    // Sort key of a record for the given policy
    function automatic logic [15:0] key_of(input task_rec_t r, input policy_t mode);
        logic [15:0] k;
        case (mode)
            POL_SJF:  k = r.burst;
            POL_SRTF: k = r.remaining;
            default:  k = {8'd0, r.prio};
        endcase
        return k;
    endfunction

    // True when a must win over b, b being nearer the head
    function automatic logic beats(input task_rec_t a, input task_rec_t b,
                                   input policy_t mode);
        logic [15:0] ka;
        logic [15:0] kb;
        logic        win;
        ka = key_of(a, mode);
        kb = key_of(b, mode);
        if (ka != kb)
            win = (ka < kb);
        else if (a.arrival != b.arrival)
            win = (a.arrival < b.arrival);
        else
            win = (a.id < b.id);
        return win;
    endfunction

    // Low bits of the entry count as reported on queue_count
    function automatic logic [QCNT_W-1:0] to_qcount(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[QCNT_W-1:0];
    endfunction

endpackage

@@ sv/rqps_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module rqps_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/rqps_engine.sv @@
`timescale 1ns / 1ps
// Queue sequencer: insert, policy scan over the record RAM and gap-closing shift.
// Depends on rqps_pkg; drives the ports of rqps_ram.
module rqps_engine
    import rqps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    input  policy_t          mode,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output task_rec_t        ram_wdata,
    output logic             ram_re,
    output logic [IDX_W-1:0] ram_raddr,
    input  task_rec_t        ram_rdata,
    output logic             done,
    output result_t          result
);

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_SHIFT  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    task_rec_t        best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [15:0]      cur_rem_reg, cur_rem_next;
    logic             done_reg, done_next;
    result_t          res_reg, res_next;

    logic [CNT_W-1:0] scan_limit;
    logic [CNT_W-1:0] count_dec;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // first-come only looks at the head
    assign scan_limit = (mode == POL_FCFS) ? CNT_W'(1) : count_reg;
    assign count_dec  = count_reg - CNT_W'(1);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        cur_valid_reg <= cur_valid_next;
        cur_rem_reg   <= cur_rem_next;
        res_reg       <= res_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        cur_valid_next = cur_valid_reg;
        cur_rem_next   = cur_rem_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = cmd.rec;
        ram_re         = 1'b0;
        ram_raddr      = issue_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next.status = STS_DONE;
                    res_next.rec    = '0;
                    cur_valid_next  = cmd.cur_valid;
                    cur_rem_next    = cmd.cur_rem;
                    if (cmd.op == OP_INSERT)
                    begin
                        done_next = 1'b1;
                        if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            res_next.status = STS_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        res_next.qcount = to_qcount(count_next);
                    end
                    else if (count_reg == '0)
                    begin
                        done_next       = 1'b1;
                        res_next.status = STS_EMPTY;
                        res_next.qcount = to_qcount(count_reg);
                    end
                    else
                    begin
                        issue_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            // stream entries out of the RAM, keep the running winner
            S_SCAN:
            begin
                if (issue_reg < scan_limit)
                begin
                    ram_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (pend_idx_reg == '0 || beats(ram_rdata, best_reg, mode))
                    begin
                        best_next     = ram_rdata;
                        best_idx_next = pend_idx_reg;
                    end
                    if (CNT_W'(pend_idx_reg) == scan_limit - CNT_W'(1))
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            // preemption check: keep the running task, else start closing the gap
            S_DECIDE:
            begin
                if (mode == POL_SRTF && cur_valid_reg &&
                    cur_rem_reg <= best_reg.remaining)
                begin
                    done_next       = 1'b1;
                    res_next.status = STS_KEPT;
                    res_next.rec    = '0;
                    res_next.qcount = to_qcount(count_reg);
                    state_next      = S_IDLE;
                end
                else
                begin
                    issue_next = CNT_W'(best_idx_reg) + CNT_W'(1);
                    state_next = S_SHIFT;
                end
            end

            // read entry i+1, write it back at i on the next cycle
            S_SHIFT:
            begin
                if (issue_reg < count_reg)
                begin
                    ram_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg - IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                else if (issue_reg >= count_reg)
                begin
                    count_next      = count_dec;
                    done_next       = 1'b1;
                    res_next.status = STS_DONE;
                    res_next.rec    = best_reg;
                    res_next.qcount = to_qcount(count_dec);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ready_queue_policy_selector_unit.sv @@
`timescale 1ns / 1ps
// Top level of the ready queue policy selector: policy register, record RAM, sequencer.
// Depends on rqps_pkg, rqps_ram and rqps_engine.
//
//  channel   | handshake              | beat
//  ----------+------------------------+--------------------------------------------
//  command   | start & !busy          | operation, task record, current_valid/_remaining
//  config    | cfg_valid & cfg_ready  | cfg_data = policy_mode
//  result    | result_valid (1 cycle) | status, picked_* record, queue_count
//
// Insert and select-on-empty answer in the cycle after accept.
// Other selects scan the entries with one RAM read per cycle (only the head for
// first-come), then answer when the running task is kept; else the entries
// behind the winner move down one slot, one read and one write per cycle, and the
// select answers once the tail has moved. busy is high only while a select scans,
// decides or shifts, and is low in the result cycle. Reset clears the count and
// the policy; RAM contents stay unset until written. The result receiver cannot stall.
module ready_queue_policy_selector_unit
    import rqps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic [7:0]        task_id,
    input  logic [15:0]       arrival_tick,
    input  logic [15:0]       burst_time,
    input  logic [15:0]       remaining_ticks,
    input  logic [7:0]        task_priority,
    input  logic              current_valid,
    input  logic [15:0]       current_remaining,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data,
    output logic              result_valid,
    output logic [1:0]        status,
    output logic [7:0]        picked_id,
    output logic [15:0]       picked_arrival,
    output logic [15:0]       picked_burst,
    output logic [15:0]       picked_remaining,
    output logic [7:0]        picked_priority,
    output logic [QCNT_W-1:0] queue_count
);

    policy_t          mode_reg;
    cmd_t             cmd;
    result_t          res;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    task_rec_t        ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [REC_W-1:0] ram_rdata_raw;

    // policy register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= POL_FCFS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= policy_t'(cfg_data);
        end
    end

    // command beat
    always_comb
    begin
        cmd               = '0;
        cmd.op            = op_t'(operation);
        cmd.rec.id        = task_id;
        cmd.rec.arrival   = arrival_tick;
        cmd.rec.burst     = burst_time;
        cmd.rec.remaining = remaining_ticks;
        cmd.rec.prio      = task_priority;
        cmd.cur_valid     = current_valid;
        cmd.cur_rem       = current_remaining;
    end

    rqps_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (REC_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    rqps_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .mode      (mode_reg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (task_rec_t'(ram_rdata_raw)),
        .done      (result_valid),
        .result    (res)
    );

    // result beat
    assign status           = res.status;
    assign picked_id        = res.rec.id;
    assign picked_arrival   = res.rec.arrival;
    assign picked_burst     = res.rec.burst;
    assign picked_remaining = res.rec.remaining;
    assign picked_priority  = res.rec.prio;
    assign queue_count      = res.qcount;

endmodule
